FILE: hw/rtl/lad_pkg.sv
// ----------------------------------------------------------------------------
// lad_pkg
// Shared types and constants for the level anomaly detector.
// ----------------------------------------------------------------------------
package lad_pkg;

  // Number of sensor channels with stored state
  localparam int CHANNELS = 2;
  localparam int CHAN_W   = 1;
  localparam int LEVEL_W  = 10;
  localparam int SEQ_W    = 32;
  localparam int RAPID_W  = 10;
  localparam int BAND_W   = 8;
  localparam int STUCK_W  = 16;
  localparam int IVL_W    = 16;
  localparam int KIND_W   = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Minute threshold scaled to seconds: stuck_minutes * 60
  localparam int SECONDS_PER_MINUTE = 60;
  localparam int STUCK_SEC_W        = STUCK_W + 6;
  localparam int PROD_W             = SEQ_W + IVL_W;

  // Baseline entry held in the state memory
  localparam int BASE_W = LEVEL_W + SEQ_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAPID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STUCK    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd3;

  localparam logic [RAPID_W-1:0] RAPID_RESET    = 10'd50;
  localparam logic [BAND_W-1:0]  BAND_RESET     = 8'd2;
  localparam logic [STUCK_W-1:0] STUCK_RESET    = 16'd120;
  localparam logic [IVL_W-1:0]   INTERVAL_RESET = 16'd30;

  // Alert codes
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RISE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STUCK = 2'd3;

  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] tank_level;
    logic [SEQ_W-1:0]   reading_seq;
    logic               sensor_ok;
  } lad_in_t;

  typedef struct packed {
    logic              is_alert;
    logic [KIND_W-1:0] alert_kind;
  } lad_out_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [SEQ_W-1:0]   seq;
  } lad_base_t;

endpackage

FILE: hw/rtl/lad_ram.sv
// ----------------------------------------------------------------------------
// lad_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_W-1:0]    raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read-first: a same-address write shows up on the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/level_anomaly_detector.sv
// ----------------------------------------------------------------------------
// level_anomaly_detector
// Per-channel tank level anomaly checker with a memory-held baseline.
// ----------------------------------------------------------------------------
// One reading per cycle is accepted while in_stall is low; each produces
// exactly one result, which passes stage 1, stage 2, stage 3 and the output
// register before out_valid rises. The per-channel baseline (level and
// sequence number) lives in a small RAM read at acceptance and written back
// from stage 1 as the reading moves on; a one-entry forwarding register
// covers a reading on the same channel that follows directly. Baseline-valid
// flags sit in flip-flops cleared by reset, so no clearing pass is needed.
// The stuck check compares (seq delta * sample interval) against
// stuck_minutes * 60, which gives the same answer as the truncated minute
// count; the 32x16 multiply has a stage of its own. Each stage stalls only
// when the one after it is full and stalled, so the block keeps taking
// transactions while a finished result waits. Configuration writes are
// expected only while the block is idle.
// ----------------------------------------------------------------------------
module level_anomaly_detector
  import lad_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lad_in_t               in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output lad_out_t              out_data,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [RAPID_W-1:0] rapid_r;
  logic [BAND_W-1:0]  band_r;
  logic [STUCK_W-1:0] stuck_r;
  logic [IVL_W-1:0]   ivl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rapid_r <= RAPID_RESET;
      band_r  <= BAND_RESET;
      stuck_r <= STUCK_RESET;
      ivl_r   <= INTERVAL_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RAPID:    rapid_r <= cfg_wdata[RAPID_W-1:0];
        REG_BAND:     band_r  <= cfg_wdata[BAND_W-1:0];
        REG_STUCK:    stuck_r <= cfg_wdata[STUCK_W-1:0];
        REG_INTERVAL: ivl_r   <= cfg_wdata[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage moves when the next one is empty or moving
  // --------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic out_adv, s3_adv, s2_adv, s1_adv, in_acc;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s3_adv   = !s3_v_r || out_adv;
  assign s2_adv   = !s2_v_r || s3_adv;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_stall = !s1_adv;
  assign in_acc   = in_valid && s1_adv;

  // --------------------------------------------------------------------------
  // Baseline memory, valid flags and forwarding
  // --------------------------------------------------------------------------
  lad_in_t            s1_item_r;
  lad_base_t          ram_rd;
  lad_base_t          base;
  logic [CHANNELS-1:0] has_base_r;
  logic               wr_en;
  lad_base_t          wr_data;

  logic               fwd_v_r;
  logic [CHAN_W-1:0]  fwd_ch_r;
  lad_base_t          fwd_data_r;

  lad_ram #(
    .WIDTH (BASE_W),
    .DEPTH (CHANNELS)
  ) u_base_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_item_r.channel),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (in_data.channel),
    .rdata (ram_rd)
  );

  // A write made at the same edge as this transaction's read is not in ram_rd
  assign base = (fwd_v_r && fwd_ch_r == s1_item_r.channel) ? fwd_data_r : ram_rd;

  // --------------------------------------------------------------------------
  // Stage 1: level compare and baseline update
  // --------------------------------------------------------------------------
  logic                  ch_in_range;
  logic                  has_base;
  logic signed [LEVEL_W+1:0] delta;
  logic signed [LEVEL_W+1:0] drop_sum;
  logic signed [LEVEL_W+1:0] rise_dif;
  logic [LEVEL_W-1:0]    mag;
  logic                  moved;
  logic [KIND_W-1:0]     s1_kind;
  logic                  s1_cand;
  logic [SEQ_W-1:0]      readings;

  assign ch_in_range = (32'(s1_item_r.channel) < CHANNELS);
  assign has_base    = has_base_r[s1_item_r.channel];

  assign delta    = $signed({2'b00, s1_item_r.tank_level}) - $signed({2'b00, base.level});
  assign drop_sum = delta + $signed({2'b00, rapid_r});
  assign rise_dif = delta - $signed({2'b00, rapid_r});
  assign mag      = delta[LEVEL_W+1] ? LEVEL_W'(-delta) : delta[LEVEL_W-1:0];
  assign moved    = (mag > LEVEL_W'(band_r));
  assign readings = s1_item_r.reading_seq - base.seq;
  assign wr_data  = '{level: s1_item_r.tank_level, seq: s1_item_r.reading_seq};

  always_comb begin
    s1_kind = KIND_NONE;
    s1_cand = 1'b0;
    wr_en   = 1'b0;
    if (s1_v_r && s2_adv) begin
      if (!s1_item_r.sensor_ok) begin
        s1_kind = KIND_STUCK;
      end else if (!ch_in_range) begin
        s1_kind = KIND_NONE;
      end else if (!has_base) begin
        wr_en = 1'b1;
      end else begin
        if (drop_sum <= 0) begin
          s1_kind = KIND_DROP;
        end else if (rise_dif >= 0) begin
          s1_kind = KIND_RISE;
        end else begin
          // stuck only if the elapsed time also reaches the limit (stage 3)
          s1_cand = !moved;
        end
        wr_en = moved;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: elapsed time product; stage 3: compare against the limit
  // --------------------------------------------------------------------------
  logic [KIND_W-1:0]      s2_kind_r, s3_kind_r;
  logic                   s2_cand_r, s3_cand_r;
  logic [SEQ_W-1:0]       s2_readings_r;
  logic [PROD_W-1:0]      s3_prod_r;
  logic [STUCK_SEC_W-1:0] stuck_sec;
  logic                   stuck_hit;
  logic [KIND_W-1:0]      s3_kind;
  lad_out_t               out_data_r;

  // stuck_minutes * 60 = (x << 6) - (x << 2)
  assign stuck_sec = ({stuck_r, 6'd0}) - STUCK_SEC_W'({stuck_r, 2'd0});
  assign stuck_hit = (s3_prod_r >= PROD_W'(stuck_sec));
  assign s3_kind   = (s3_cand_r && stuck_hit) ? KIND_STUCK : s3_kind_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      has_base_r  <= '0;
      fwd_v_r     <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r  <= in_acc;
        fwd_v_r <= wr_en;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_adv) begin
        s3_v_r <= s2_v_r;
      end
      if (out_adv) begin
        out_valid_r <= s3_v_r;
      end
      if (wr_en) begin
        has_base_r[s1_item_r.channel] <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      fwd_ch_r   <= s1_item_r.channel;
      fwd_data_r <= wr_data;
    end
    if (s2_adv) begin
      s2_kind_r     <= s1_kind;
      s2_cand_r     <= s1_cand;
      s2_readings_r <= readings;
    end
    if (s3_adv) begin
      s3_kind_r <= s2_kind_r;
      s3_cand_r <= s2_cand_r;
      s3_prod_r <= PROD_W'(s2_readings_r) * PROD_W'(ivl_r);
    end
    if (out_adv) begin
      out_data_r.is_alert   <= (s3_kind != KIND_NONE);
      out_data_r.alert_kind <= s3_kind;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: verif/lad_alert_checker.sv
// ----------------------------------------------------------------------------
// lad_alert_checker
// Watches the channels of the level anomaly detector and checks its alerts.
// ----------------------------------------------------------------------------
// Every reading accepted on the input channel is classified against a local
// copy of the per-channel baselines and the configuration registers. The
// resulting alert goes into a FIFO. Every accepted result is checked field by
// field against the oldest alert in the FIFO.
// ----------------------------------------------------------------------------
module lad_alert_checker
  import lad_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  lad_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  lad_out_t              out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    alerts_in_flight
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 40;

  logic [RAPID_W-1:0] rapid_cm;
  logic [BAND_W-1:0]  band_cm;
  logic [STUCK_W-1:0] stuck_min;
  logic [IVL_W-1:0]   ivl_s;

  logic [LEVEL_W-1:0] base_level [CHANNELS];
  logic [SEQ_W-1:0]   base_seq   [CHANNELS];
  logic               has_base   [CHANNELS];

  lad_out_t pending_alerts [$];
  lad_out_t oldest_alert;

  task automatic report(input string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t ns: MISMATCH %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Classifies one accepted reading and updates the local baselines.
  function automatic lad_out_t classify_reading(input lad_in_t rd);
    lad_out_t         res;
    int               ch;
    int               delta;
    int               mag;
    logic [SEQ_W-1:0] readings;
    logic [63:0]      minutes;
    ch             = int'(rd.channel);
    res.alert_kind = KIND_NONE;
    if (!rd.sensor_ok) begin
      res.alert_kind = KIND_STUCK;
    end else if (ch < CHANNELS) begin
      if (!has_base[ch]) begin
        base_level[ch] = rd.tank_level;
        base_seq[ch]   = rd.reading_seq;
        has_base[ch]   = 1'b1;
      end else begin
        delta    = int'(rd.tank_level) - int'(base_level[ch]);
        mag      = (delta < 0) ? -delta : delta;
        readings = rd.reading_seq - base_seq[ch];
        minutes  = (64'(readings) * 64'(ivl_s)) / SECONDS_PER_MINUTE;
        // drop wins over rise, rise over stuck
        if (delta <= -int'(rapid_cm)) begin
          res.alert_kind = KIND_DROP;
        end else if (delta >= int'(rapid_cm)) begin
          res.alert_kind = KIND_RISE;
        end else if (minutes >= 64'(stuck_min) && mag <= int'(band_cm)) begin
          res.alert_kind = KIND_STUCK;
        end
        if (mag > int'(band_cm)) begin
          base_level[ch] = rd.tank_level;
          base_seq[ch]   = rd.reading_seq;
        end
      end
    end
    res.is_alert = (res.alert_kind != KIND_NONE);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mismatch_count = 0;
      rapid_cm  = RAPID_RESET;
      band_cm   = BAND_RESET;
      stuck_min = STUCK_RESET;
      ivl_s     = INTERVAL_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        base_level[i] = '0;
        base_seq[i]   = '0;
        has_base[i]   = 1'b0;
      end
      pending_alerts.delete();
    end else begin
      // a result never belongs to a reading taken at the same edge
      if (out_valid && !out_stall) begin
        if (pending_alerts.size() == 0) begin
          report($sformatf("result %b/%0d with no reading waiting",
                           out_data.is_alert, out_data.alert_kind));
        end else begin
          oldest_alert = pending_alerts.pop_front();
          if (out_data.is_alert !== oldest_alert.is_alert) begin
            report($sformatf("is_alert %b, want %b",
                             out_data.is_alert, oldest_alert.is_alert));
          end
          if (out_data.alert_kind !== oldest_alert.alert_kind) begin
            report($sformatf("alert_kind %0d, want %0d",
                             out_data.alert_kind, oldest_alert.alert_kind));
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_alerts.push_back(classify_reading(in_data));
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_RAPID:    rapid_cm  = cfg_wdata[RAPID_W-1:0];
          REG_BAND:     band_cm   = cfg_wdata[BAND_W-1:0];
          REG_STUCK:    stuck_min = cfg_wdata[STUCK_W-1:0];
          REG_INTERVAL: ivl_s     = cfg_wdata[IVL_W-1:0];
          default: ;
        endcase
      end
    end
    alerts_in_flight <= pending_alerts.size();
  end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top-level testbench for the level anomaly detector.
// ----------------------------------------------------------------------------
// Drives readings through the block in phases, each under its own register
// setting, with a short directed part at the start covering thresholds,
// band edges, sensor failure, first readings and sequence wrap. Random
// readings follow plausible per-channel level and sequence trajectories so
// that baselines, rapid alerts and stuck alerts are all reached. The sender
// works in bursts, the receiver stalls on its own pattern. Checking happens
// in lad_alert_checker; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb
  import lad_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES       = 9;
  localparam int RAND_ITEMS   = 112;  // per phase, ~1000 overall
  localparam int DRAIN_CYCLES = 8;    // pipeline is four deep

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  lad_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  lad_out_t              out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_RAPID;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatch_count;
  int alerts_in_flight;

  // Current register values, used only to aim the random stimulus
  int cur_rapid = int'(RAPID_RESET);
  int cur_band  = int'(BAND_RESET);
  int cur_stuck = int'(STUCK_RESET);
  int cur_ivl   = int'(INTERVAL_RESET);

  // Stimulus trajectory per channel: last level sent, running sequence
  int          stim_lvl [CHANNELS];
  logic [31:0] stim_seq [CHANNELS];

  // Register settings per phase: rapid, band, stuck, interval.
  // Phase 0 runs on reset values; 7 and 8 are drawn at run time.
  int phase_cfg [PHASES][4] = '{
    '{50, 2, 120, 30},
    '{0, 0, 0, 0},
    '{1023, 255, 1, 0},
    '{1, 0, 65535, 65535},
    '{1023, 255, 65535, 1},
    '{10, 3, 0, 60},
    '{50, 2, 120, 30},
    '{0, 0, 0, 0},
    '{0, 0, 0, 0}
  };

  level_anomaly_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lad_alert_checker alert_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .alerts_in_flight (alerts_in_flight)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("level_anomaly_detector test failed");
    $finish;
  end

  // Receiver: stall pattern switches mode every so often -- none, light
  // random, heavy random, periodic.
  int stall_mode = 0;
  int stall_left = 64;
  int stall_tick = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(32, 256);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 99) < 25);
        2:       out_stall <= ($urandom_range(0, 99) < 70);
        default: out_stall <= ((stall_tick % 5) < 2);
      endcase
    end
  end

  function automatic lad_in_t reading(input int ch, input int lvl,
                                      input logic [31:0] seq, input logic ok);
    lad_in_t r;
    r.channel     = ch[CHAN_W-1:0];
    r.tank_level  = lvl[LEVEL_W-1:0];
    r.reading_seq = seq;
    r.sensor_ok   = ok;
    return r;
  endfunction

  // A transaction on the input channel. Called right after the clock rises;
  // valid stays high if the caller sends again immediately.
  task automatic send_reading(input lad_in_t r);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off the sender until every predicted alert has been seen.
  task automatic drain_alerts();
    in_valid <= 1'b0;
    @(posedge clk);
    while (alerts_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers back to back; block must be idle.
  task automatic write_config(input logic [CFG_DATA_W-1:0] d [4]);
    logic [CFG_IDX_W-1:0] idx [4];
    idx = '{REG_RAPID, REG_BAND, REG_STUCK, REG_INTERVAL};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= d[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    cur_rapid = int'(d[0][RAPID_W-1:0]);
    cur_band  = int'(d[1][BAND_W-1:0]);
    cur_stuck = int'(d[2][STUCK_W-1:0]);
    cur_ivl   = int'(d[3][IVL_W-1:0]);
  endtask

  // Random reading that mostly follows the channel's trajectory: small moves
  // around the still band, moves around the rapid threshold, and sequence
  // jumps that land near the stuck limit; the rest is noise.
  task automatic next_reading(output lad_in_t r);
    int          ch;
    int          lvl;
    int          pick;
    longint      span;
    logic [31:0] step;
    ch   = $urandom_range(0, CHANNELS - 1);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      lvl = stim_lvl[ch] + int'($urandom_range(0, 2 * cur_band + 2)) - cur_band - 1;
    end else if (pick < 70) begin
      lvl = cur_rapid + int'($urandom_range(0, 2)) - 1;
      lvl = $urandom_range(0, 1) ? stim_lvl[ch] + lvl : stim_lvl[ch] - lvl;
    end else if (pick < 85) begin
      lvl = stim_lvl[ch] + int'($urandom_range(0, 200)) - 100;
    end else begin
      lvl = int'($urandom_range(0, 1023));
    end
    if (lvl < 0) lvl = 0;
    if (lvl > 1023) lvl = 1023;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      step = $urandom_range(0, 3);
    end else if (pick < 85) begin
      if (cur_ivl == 0) begin
        span = longint'($urandom_range(0, 1000));
      end else begin
        span = (longint'(cur_stuck) * SECONDS_PER_MINUTE + cur_ivl - 1) / cur_ivl;
      end
      span = span + longint'($urandom_range(0, 4)) - 2;
      step = span[31:0];
    end else if (pick < 95) begin
      step = $urandom;
    end else begin
      step = 32'(-int'($urandom_range(1, 8)));  // backwards, wraps
    end
    stim_seq[ch] = stim_seq[ch] + step;
    stim_lvl[ch] = lvl;
    r = reading(ch, lvl, stim_seq[ch], ($urandom_range(0, 99) >= 8));
  endtask

  // Random part of a phase: bursts of transactions with random gaps, and one
  // full drain partway through.
  task automatic run_random(input int n);
    lad_in_t r;
    int      burst_left;
    burst_left = $urandom_range(1, 40);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain_alerts();
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      next_reading(r);
      send_reading(r);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] d [4];
    for (int i = 0; i < CHANNELS; i++) begin
      stim_lvl[i] = int'($urandom_range(0, 1023));
      stim_seq[i] = $urandom;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: rapid 50, band 2, stuck 120 min, interval 30 s
    send_reading(reading(0, 0, 32'd0, 1'b0));            // failure, no baseline
    send_reading(reading(0, 500, 32'd1000, 1'b1));       // first reading
    send_reading(reading(0, 450, 32'd1001, 1'b1));       // drop at threshold
    send_reading(reading(0, 499, 32'd1002, 1'b1));       // rise one short
    send_reading(reading(0, 549, 32'd1003, 1'b1));       // rise at threshold
    send_reading(reading(0, 551, 32'd1242, 1'b1));       // 119 min, in band
    send_reading(reading(0, 547, 32'd1243, 1'b1));       // 120 min: stuck
    send_reading(reading(0, 1023, 32'd7, 1'b0));         // failure, state kept
    send_reading(reading(0, 552, 32'd1244, 1'b1));       // just outside band
    send_reading(reading(1, 1023, 32'hFFFF_FF80, 1'b1)); // first on channel 1
    send_reading(reading(1, 1023, 32'h0000_0070, 1'b1)); // stuck across wrap
    send_reading(reading(1, 0, 32'hFFFF_FFFF, 1'b1));    // full-scale drop
    send_reading(reading(1, 1023, 32'd0, 1'b1));         // full-scale rise
    send_reading(reading(1, 1023, 32'd0, 1'b1));         // no change, no time
    send_reading(reading(0, 0, 32'd5, 1'b1));            // drop, seq wrapped
    run_random(RAND_ITEMS);

    for (int p = 1; p < PHASES; p++) begin
      drain_alerts();
      for (int k = 0; k < 4; k++) d[k] = CFG_DATA_W'(phase_cfg[p][k]);
      if (p == 7) begin
        // full-width data, upper bits must be ignored
        for (int k = 0; k < 4; k++) d[k] = CFG_DATA_W'($urandom);
      end else if (p == 8) begin
        d = '{CFG_DATA_W'($urandom_range(1, 1023)), CFG_DATA_W'($urandom_range(0, 255)),
              CFG_DATA_W'($urandom_range(0, 300)), CFG_DATA_W'($urandom_range(1, 600))};
      end
      write_config(d);
      if (p == 1) begin
        // zero threshold: no change counts as drop, any rise as rise
        send_reading(reading(0, 300, 32'd10, 1'b1));
        send_reading(reading(0, 300, 32'd11, 1'b1));
        send_reading(reading(0, 301, 32'd12, 1'b1));
      end else if (p == 2) begin
        // zero interval: elapsed time never reaches a nonzero limit
        send_reading(reading(1, 600, 32'd20, 1'b1));
        send_reading(reading(1, 700, 32'h8000_0000, 1'b1));
        send_reading(reading(1, 1000, 32'd3, 1'b1));
      end else if (p == 5) begin
        // zero stuck limit: any in-band reading is stuck
        send_reading(reading(0, 200, 32'd40, 1'b1));
        send_reading(reading(0, 203, 32'd40, 1'b1));
      end
      run_random(RAND_ITEMS);
    end

    drain_alerts();
    if (mismatch_count == 0 && alerts_in_flight == 0) begin
      $display("level_anomaly_detector test passed");
    end else begin
      $display("level_anomaly_detector test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lad_pkg.sv
hw/rtl/lad_ram.sv
hw/rtl/level_anomaly_detector.sv
verif/lad_alert_checker.sv
verif/tb.sv
